// ----- rtl/binary_greedy_pursuit_row_assert.svh -----
// assertion macros for the greedy pursuit row block
`ifndef BINARY_GREEDY_PURSUIT_ROW_ASSERT_SVH
`define BINARY_GREEDY_PURSUIT_ROW_ASSERT_SVH

// same-cycle implication
`define BGP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BGP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/bgp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgp_pkg
// shared types, constants and the popcount function of the greedy pursuit row
// ----------------------------------------------------------------------------
package bgp_pkg;

  localparam int DefRowBits = 64;
  localparam int DefAtoms   = 32;
  localparam int RowW       = 64;
  localparam int CoefW      = 32;
  localparam int CntW       = 7;
  localparam int IdxW       = 5;
  localparam int ErrW       = 7;
  localparam int CoefCntW   = 6;
  localparam int AtomCntW   = 6;
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 7;

  localparam logic [ErrW-1:0]     RstMaxErr  = 7'd0;
  localparam logic [CoefCntW-1:0] RstMaxCoef = 6'd32;
  localparam logic [AtomCntW-1:0] RstAtoms   = 6'd32;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MAX_ERR  = 2'd0,
    REG_MAX_COEF = 2'd1,
    REG_ATOMS    = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_EVAL,
    ST_DONE
  } eng_state_e;

  typedef struct packed {
    logic [ErrW-1:0]     max_err;
    logic [CoefCntW-1:0] max_coef;
    logic [AtomCntW-1:0] atoms;
  } bgp_cfg_t;

  typedef struct packed {
    logic [RowW-1:0]  residual;
    logic [CoefW-1:0] coefs;
    logic             changed;
  } bgp_result_t;

  typedef struct packed {
    logic busy;
    logic push;
  } bgp_status_t;

  function automatic logic [CntW-1:0] popcnt64(logic [RowW-1:0] v);
    logic [CntW-1:0] n;
    n = '0;
    for (int i = 0; i < RowW; i++) begin
      n = n + CntW'(v[i]);
    end
    return n;
  endfunction

endpackage

// ----- rtl/bgp_atom_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgp_atom_mem
// dictionary store, one write port and one registered read port
// ----------------------------------------------------------------------------
module bgp_atom_mem import bgp_pkg::*; #(
  parameter int ROW_BITS = DefRowBits,
  parameter int ATOMS    = DefAtoms,
  localparam int AW      = $clog2(ATOMS)
) (
  input  logic                clk_i,
  input  logic                wr_en_i,
  input  logic [AW-1:0]       wr_addr_i,
  input  logic [ROW_BITS-1:0] wr_data_i,
  input  logic                rd_en_i,
  input  logic [AW-1:0]       rd_addr_i,
  output logic [ROW_BITS-1:0] rd_data_o
);

  logic [ROW_BITS-1:0] mem_q [ATOMS];
  logic [ROW_BITS-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- rtl/bgp_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgp_engine
// greedy search sequencer: scans the atom store once per step, applies the
// closest atom and repeats until a stop condition holds
// ----------------------------------------------------------------------------
module bgp_engine import bgp_pkg::*; #(
  parameter int ROW_BITS = DefRowBits,
  parameter int ATOMS    = DefAtoms,
  localparam int AW      = $clog2(ATOMS),
  localparam int Limit   = (ATOMS < CoefW) ? ATOMS : CoefW
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [RowW-1:0]     residual_i,
  input  logic [CoefW-1:0]    coefs_i,
  input  bgp_cfg_t            cfg_i,
  output logic                rd_en_o,
  output logic [AW-1:0]       rd_addr_o,
  input  logic [ROW_BITS-1:0] rd_data_i,
  input  logic                out_free_i,
  output bgp_result_t         result_o,
  output bgp_status_t         status_o
);

  eng_state_e          state_q, state_d;
  logic [ROW_BITS-1:0] res_q, res_d;
  logic [CoefW-1:0]    coef_q, coef_d;
  logic                chg_q, chg_d;
  logic [CntW-1:0]     w_q, w_d;
  logic [AW-1:0]       last_q, last_d;
  logic [AW-1:0]       iss_q, iss_d;
  logic                iss_done_q, iss_done_d;
  logic                rv_q, rv_d;
  logic [AW-1:0]       ridx_q, ridx_d;
  logic [CntW-1:0]     best_d_q, best_d_d;
  logic [AW-1:0]       best_k_q, best_k_d;
  logic [ROW_BITS-1:0] best_atom_q, best_atom_d;

  logic [CntW-1:0] res_w;
  logic [CntW-1:0] coef_w;
  logic [CntW-1:0] ham_dist;

  assign res_w    = popcnt64(RowW'(res_q));
  assign coef_w   = popcnt64(RowW'(coef_q));
  assign ham_dist = popcnt64(RowW'(res_q ^ rd_data_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      iss_done_q <= 1'b0;
      rv_q       <= 1'b0;
    end else begin
      state_q    <= state_d;
      iss_done_q <= iss_done_d;
      rv_q       <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q       <= res_d;
    coef_q      <= coef_d;
    chg_q       <= chg_d;
    w_q         <= w_d;
    last_q      <= last_d;
    iss_q       <= iss_d;
    ridx_q      <= ridx_d;
    best_d_q    <= best_d_d;
    best_k_q    <= best_k_d;
    best_atom_q <= best_atom_d;
  end

  always_comb begin
    state_d     = state_q;
    res_d       = res_q;
    coef_d      = coef_q;
    chg_d       = chg_q;
    w_d         = w_q;
    last_d      = last_q;
    iss_d       = iss_q;
    iss_done_d  = iss_done_q;
    rv_d        = 1'b0;
    ridx_d      = iss_q;
    best_d_d    = best_d_q;
    best_k_d    = best_k_q;
    best_atom_d = best_atom_q;
    rd_en_o     = 1'b0;
    rd_addr_o   = iss_q;
    status_o    = '{busy: (state_q != ST_IDLE), push: 1'b0};

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          res_d  = residual_i[ROW_BITS-1:0];
          coef_d = coefs_i;
          chg_d  = 1'b0;
          // searched atom count, clamped to one .. limit
          if (cfg_i.atoms == '0) begin
            last_d = '0;
          end else if (int'(cfg_i.atoms) > Limit) begin
            last_d = AW'(Limit - 1);
          end else begin
            last_d = AW'(cfg_i.atoms - AtomCntW'(1));
          end
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (res_w <= cfg_i.max_err || coef_w >= CntW'(cfg_i.max_coef)) begin
          state_d = ST_DONE;
        end else begin
          w_d        = res_w;
          iss_d      = '0;
          iss_done_d = 1'b0;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!iss_done_q) begin
          rd_en_o = 1'b1;
          rv_d    = 1'b1;
          if (iss_q == last_q) begin
            iss_done_d = 1'b1;
          end else begin
            iss_d = iss_q + AW'(1);
          end
        end
        if (rv_q) begin
          if (ridx_q == '0 || ham_dist < best_d_q) begin
            best_d_d    = ham_dist;
            best_k_d    = ridx_q;
            best_atom_d = rd_data_i;
          end
          if (ridx_q == last_q) begin
            state_d = ST_EVAL;
          end
        end
      end
      ST_EVAL: begin
        if (best_d_q < w_q) begin
          res_d   = res_q ^ best_atom_q;
          coef_d  = coef_q ^ (CoefW'(1) << best_k_q);
          chg_d   = 1'b1;
          state_d = ST_CHECK;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free_i) begin
          status_o.push = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign result_o = '{residual: RowW'(res_q), coefs: coef_q, changed: chg_q};

endmodule

// ----- rtl/binary_greedy_pursuit_row.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_greedy_pursuit_row
// greedy GF(2) sparse coding of one residual row over a stored atom dictionary
// ----------------------------------------------------------------------------
// A load beat writes one atom and leaves the block free for the next beat. An
// encode beat checks the limits, then scans the searched atoms, applies the
// closest one and checks again, until a limit holds or no atom lowers the
// residual weight; its result then enters the output register once that is
// free. Each pass reads the atom store one entry per cycle through its single
// read port, and that scan sets the rate. One item is worked on at a time; a
// finished result waits in the output register while the next beat is taken.
// Atoms read before they were written return undefined data.
module binary_greedy_pursuit_row import bgp_pkg::*; #(
  parameter int ROW_BITS = DefRowBits,
  parameter int ATOMS    = DefAtoms
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                mode_i,
  input  logic [IdxW-1:0]     atom_index_i,
  input  logic [RowW-1:0]     atom_bits_i,
  input  logic [RowW-1:0]     residual_row_i,
  input  logic [CoefW-1:0]    coef_row_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [RowW-1:0]     new_residual_o,
  output logic [CoefW-1:0]    new_coefs_o,
  output logic                changed_o
);

  localparam int AW = $clog2(ATOMS);

  bgp_cfg_t            cfg_q, cfg_d;
  bgp_result_t         out_q;
  logic                out_valid_q, out_valid_d;
  bgp_result_t         eng_result;
  bgp_status_t         eng_status;
  logic                accept;
  logic                out_free;
  logic                mem_we;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic [ROW_BITS-1:0] rd_data;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MAX_ERR:  cfg_d.max_err  = cfg_data_i[ErrW-1:0];
        REG_MAX_COEF: cfg_d.max_coef = cfg_data_i[CoefCntW-1:0];
        REG_ATOMS:    cfg_d.atoms    = cfg_data_i[AtomCntW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= '{max_err: RstMaxErr, max_coef: RstMaxCoef, atoms: RstAtoms};
      out_valid_q <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o = eng_status.busy;
  assign accept     = in_valid_i && !in_stall_o;
  assign mem_we     = accept && !mode_i && (int'(atom_index_i) < ATOMS);
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (eng_status.push) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (eng_status.push) begin
      out_q <= eng_result;
    end
  end

  bgp_atom_mem #(
    .ROW_BITS (ROW_BITS),
    .ATOMS    (ATOMS)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_we),
    .wr_addr_i (AW'(atom_index_i)),
    .wr_data_i (atom_bits_i[ROW_BITS-1:0]),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  bgp_engine #(
    .ROW_BITS (ROW_BITS),
    .ATOMS    (ATOMS)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept && mode_i),
    .residual_i (residual_row_i),
    .coefs_i    (coef_row_i),
    .cfg_i      (cfg_q),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .rd_data_i  (rd_data),
    .out_free_i (out_free),
    .result_o   (eng_result),
    .status_o   (eng_status)
  );

  assign out_valid_o    = out_valid_q;
  assign new_residual_o = out_q.residual;
  assign new_coefs_o    = out_q.coefs;
  assign changed_o      = out_q.changed;

endmodule

// ----- rtl/bgp_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgp_checker
// port-level checks for the greedy pursuit row block
// ----------------------------------------------------------------------------
`include "binary_greedy_pursuit_row_assert.svh"

module bgp_checker import bgp_pkg::*; #(
  parameter int ROW_BITS = DefRowBits
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                mode_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic [RowW-1:0]     new_residual_o,
  input logic [CoefW-1:0]    new_coefs_o,
  input logic                changed_o
);

  `BGP_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(new_residual_o) && $stable(new_coefs_o) && $stable(changed_o), "stalled result beat changed")
  `BGP_ASSERT_NEXT(a_encode_busy, in_valid_i && !in_stall_o && mode_i, in_stall_o, "encode beat did not occupy the block")
  `BGP_ASSERT_NEXT(a_load_free, in_valid_i && !in_stall_o && !mode_i, !in_stall_o, "load beat stalled the input")
  `BGP_ASSERT_NOW(a_row_width, out_valid_o, (new_residual_o >> ROW_BITS) == '0, "residual bits above row width set")

endmodule

bind binary_greedy_pursuit_row bgp_checker #(.ROW_BITS(ROW_BITS)) u_bgp_checker (.*);

// ----- tb/tb_binary_greedy_pursuit_row.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_binary_greedy_pursuit_row
// self-checking testbench for the greedy GF(2) row encoder
// ----------------------------------------------------------------------------
// Atom loads and row encodes go in through the valid/stall input channel. The
// bench keeps its own copy of the dictionary and of the three limit registers
// and works out every encode result with its own greedy search, then checks
// the results in order, field by field, while both channels idle and stall at
// random. Limits change only while the block is drained: a few directed
// corner rows first, then random phases whose rows are mostly XOR mixes of
// stored atoms with a little noise, so the search runs many steps deep.
// ----------------------------------------------------------------------------
module tb_binary_greedy_pursuit_row;
  import bgp_pkg::*;

  localparam logic ModeLoad     = 1'b0;
  localparam logic ModeEncode   = 1'b1;
  localparam int   NumAtoms     = DefAtoms;
  localparam int   SettleCycles = 16;
  localparam int   CycleLimit   = 12_000_000;
  localparam int   ReportLimit  = 10;

  typedef struct {
    logic             mode;
    logic [IdxW-1:0]  index;
    logic [RowW-1:0]  atom;
    logic [RowW-1:0]  residual;
    logic [CoefW-1:0] coefs;
  } pursuit_beat_t;

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                cfg_we_i       = 1'b0;
  cfg_reg_e            cfg_idx_i      = REG_MAX_ERR;
  logic [CfgDataW-1:0] cfg_data_i     = '0;
  logic                in_valid_i     = 1'b0;
  logic                in_stall_o;
  logic                mode_i         = ModeLoad;
  logic [IdxW-1:0]     atom_index_i   = '0;
  logic [RowW-1:0]     atom_bits_i    = '0;
  logic [RowW-1:0]     residual_row_i = '0;
  logic [CoefW-1:0]    coef_row_i     = '0;
  logic                out_valid_o;
  logic                out_stall_i    = 1'b0;
  logic [RowW-1:0]     new_residual_o;
  logic [CoefW-1:0]    new_coefs_o;
  logic                changed_o;

  logic [RowW-1:0] dict_mirror [NumAtoms];
  logic [RowW-1:0] atom_plan [NumAtoms];
  int unsigned     err_lim   = RstMaxErr;
  int unsigned     coef_lim  = RstMaxCoef;
  int unsigned     atoms_lim = RstAtoms;

  pursuit_beat_t pending_beats [$];
  bgp_result_t   rows_due [$];
  int            beats_left     = 0;
  int            mismatch_cnt   = 0;
  int            send_wait      = 0;
  int            stall_left     = 0;
  int unsigned   send_gap_max   = 9;
  int unsigned   recv_stall_max = 9;
  int            cycle_cnt      = 0;

  binary_greedy_pursuit_row dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .atom_index_i   (atom_index_i),
    .atom_bits_i    (atom_bits_i),
    .residual_row_i (residual_row_i),
    .coef_row_i     (coef_row_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .new_residual_o (new_residual_o),
    .new_coefs_o    (new_coefs_o),
    .changed_o      (changed_o)
  );

  initial begin
    for (int i = 0; i < NumAtoms; i++) begin
      dict_mirror[i] = '0;
      atom_plan[i]   = '0;
    end
  end

  initial begin : clock_gen
    forever #2 clk_i = ~clk_i;
  end

  function automatic int unsigned ones_in(logic [RowW-1:0] v);
    int unsigned c;
    c = 0;
    for (int i = 0; i < RowW; i++) begin
      c += v[i];
    end
    return c;
  endfunction

  function automatic int unsigned atoms_searched();
    int unsigned n;
    n = atoms_lim;
    if (n < 1) n = 1;
    if (n > NumAtoms) n = NumAtoms;
    return n;
  endfunction

  function automatic bgp_result_t greedy_encode(logic [RowW-1:0] res, logic [CoefW-1:0] coefs);
    bgp_result_t r;
    int unsigned n, w, d, best_d, best_k;
    bit          go;
    n = atoms_searched();
    r.changed = 1'b0;
    go = 1'b1;
    while (go) begin
      w = ones_in(res);
      if (w <= err_lim || ones_in({32'd0, coefs}) >= coef_lim) begin
        go = 1'b0;
      end else begin
        best_k = 0;
        best_d = ones_in(res ^ dict_mirror[0]);
        for (int k = 1; k < n; k++) begin
          d = ones_in(res ^ dict_mirror[k]);
          if (d < best_d) begin
            best_d = d;
            best_k = k;
          end
        end
        if (best_d >= w) begin
          go = 1'b0;
        end else begin
          res = res ^ dict_mirror[best_k];
          coefs[best_k] = ~coefs[best_k];
          r.changed = 1'b1;
        end
      end
    end
    r.residual = res;
    r.coefs    = coefs;
    return r;
  endfunction

  // input beat driver
  always @(posedge clk_i) begin : beat_driver
    pursuit_beat_t nxt;
    bit            taken;
    if (rst_ni) begin
      taken = in_valid_i && !in_stall_o;
      if (taken) begin
        if (mode_i == ModeLoad) begin
          dict_mirror[atom_index_i] = atom_bits_i;
        end else begin
          rows_due.push_back(greedy_encode(residual_row_i, coef_row_i));
        end
        beats_left--;
        send_wait = $urandom_range(0, send_gap_max);
      end
      if (!in_valid_i || taken) begin
        if (send_wait == 0 && pending_beats.size() != 0) begin
          nxt = pending_beats.pop_front();
          in_valid_i     <= 1'b1;
          mode_i         <= nxt.mode;
          atom_index_i   <= nxt.index;
          atom_bits_i    <= nxt.atom;
          residual_row_i <= nxt.residual;
          coef_row_i     <= nxt.coefs;
        end else begin
          in_valid_i <= 1'b0;
          if (send_wait != 0) send_wait--;
        end
      end
    end
  end

  // result beat monitor
  always @(posedge clk_i) begin : row_monitor
    bgp_result_t want;
    int unsigned w;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (rows_due.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= ReportLimit)
            $display("result beat with no encode outstanding: residual %h coefs %h",
                     new_residual_o, new_coefs_o);
        end else begin
          want = rows_due.pop_front();
          if (new_residual_o !== want.residual || new_coefs_o !== want.coefs ||
              changed_o !== want.changed) begin
            mismatch_cnt++;
            if (mismatch_cnt <= ReportLimit) begin
              $display("row mismatch: residual exp %h got %h", want.residual, new_residual_o);
              $display("  coefs exp %h got %h, changed exp %b got %b",
                       want.coefs, new_coefs_o, want.changed, changed_o);
            end
          end
        end
        w = $urandom_range(0, recv_stall_max);
        stall_left = w;
        out_stall_i <= (w != 0);
      end else if (out_valid_o && stall_left != 0) begin
        stall_left--;
        out_stall_i <= (stall_left != 0);
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("binary_greedy_pursuit_row test failed");
      $finish;
    end
  end

  task automatic set_reg(cfg_reg_e r, int unsigned v);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= r;
    cfg_data_i <= v[CfgDataW-1:0];
    case (r)
      REG_MAX_ERR:  err_lim   = v & 127;
      REG_MAX_COEF: coef_lim  = v & 63;
      REG_ATOMS:    atoms_lim = v & 63;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_idle();
    while (beats_left != 0 || rows_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic logic [RowW-1:0] rand_row();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [RowW-1:0] sparse_row(int unsigned max_bits);
    logic [RowW-1:0] v;
    int unsigned     k;
    v = '0;
    repeat ($urandom_range(1, max_bits)) begin
      k = $urandom_range(0, RowW - 1);
      v[k] = 1'b1;
    end
    return v;
  endfunction

  function automatic logic [RowW-1:0] plan_atom();
    logic [RowW-1:0] v;
    v = '0;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: v = sparse_row(6);
      5, 6, 7:       v = rand_row();
      8:             v = ~sparse_row(6);
      default: if ($urandom_range(0, 1)) v = ~v;
    endcase
    return v;
  endfunction

  // mostly xor mixes of searched atoms plus a few flipped bits
  function automatic logic [RowW-1:0] plan_residual();
    logic [RowW-1:0] v;
    int unsigned     n, k;
    n = atoms_searched();
    v = '0;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        repeat ($urandom_range(1, 5)) begin
          k = $urandom_range(0, n - 1);
          v = v ^ atom_plan[k];
        end
        repeat ($urandom_range(0, 3)) begin
          k = $urandom_range(0, RowW - 1);
          v[k] = ~v[k];
        end
      end
      6, 7: v = rand_row();
      8:    v = sparse_row(8);
      default: if ($urandom_range(0, 1)) v = ~v;
    endcase
    return v;
  endfunction

  function automatic logic [CoefW-1:0] plan_coefs();
    logic [CoefW-1:0] c;
    int unsigned      k;
    c = '0;
    case ($urandom_range(0, 7))
      0, 1, 2, 3: begin
        repeat ($urandom_range(0, 4)) begin
          k = $urandom_range(0, CoefW - 1);
          c[k] = 1'b1;
        end
      end
      4, 5: c = $urandom;
      6:    c = $urandom | $urandom;
      default: if ($urandom_range(0, 1)) c = ~c;
    endcase
    return c;
  endfunction

  function automatic void send_load(int unsigned idx, logic [RowW-1:0] bits);
    pursuit_beat_t b;
    b.mode     = ModeLoad;
    b.index    = idx[IdxW-1:0];
    b.atom     = bits;
    b.residual = rand_row();
    b.coefs    = $urandom;
    atom_plan[idx] = bits;
    pending_beats.push_back(b);
    beats_left++;
  endfunction

  function automatic void send_encode(logic [RowW-1:0] res, logic [CoefW-1:0] coefs);
    pursuit_beat_t b;
    int unsigned   r;
    r = $urandom;
    b.mode     = ModeEncode;
    b.index    = r[IdxW-1:0];
    b.atom     = rand_row();
    b.residual = res;
    b.coefs    = coefs;
    pending_beats.push_back(b);
    beats_left++;
  endfunction

  task automatic run_phase(int unsigned err, int unsigned coef, int unsigned atoms,
                           int unsigned gap, int unsigned stall, int unsigned rows);
    wait_idle();
    set_reg(REG_MAX_ERR, err);
    set_reg(REG_MAX_COEF, coef);
    set_reg(REG_ATOMS, atoms);
    send_gap_max   = gap;
    recv_stall_max = stall;
    repeat (rows) begin
      if ($urandom_range(0, 6) == 0) send_load($urandom_range(0, NumAtoms - 1), plan_atom());
      else send_encode(plan_residual(), plan_coefs());
    end
  endtask

  initial begin : stimulus
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // corner rows over a four-atom dictionary
    set_reg(REG_ATOMS, 4);
    send_load(0, 64'h0);
    send_load(1, '1);
    send_load(2, 64'h1);
    send_load(3, 64'hFFFF_0000_0000_0000);
    send_load(31, 64'hA5A5_5A5A_C3C3_3C3C);
    send_encode(64'h0, 32'h0);
    send_encode('1, 32'h0);
    send_encode(64'h1, '1);
    send_encode(64'hFFFF_0000_0000_0001, 32'h0);
    send_encode(64'h8000_0000_0000_0000, 32'h8000_0000);
    send_encode(64'h3, 32'h0);
    send_encode('1, 32'h7FFF_FFFF);
    send_load(2, 64'hFFFF_0000_0000_0000);
    send_encode(64'hFFFF_0000_0000_0000, 32'h0);
    send_encode(64'hFFFF_0000_0000_0001, 32'h1);
    send_encode(rand_row(), $urandom);

    wait_idle();
    for (int i = 0; i < NumAtoms; i++) send_load(i, plan_atom());

    run_phase(0, 32, 32, 9, 9, 200);
    run_phase(0, 63, 63, 0, 0, 200);
    run_phase(3, 5, 17, 9, 0, 200);
    run_phase(127, 32, 32, 0, 9, 40);
    run_phase(64, 0, 32, 9, 0, 40);
    run_phase(0, 32, 0, 9, 9, 100);
    run_phase(1, 1, 2, 0, 9, 100);
    repeat (2) begin
      run_phase($urandom_range(0, 12), $urandom_range(1, 32), $urandom_range(1, 32),
                9, 9, 320);
    end

    wait_idle();
    if (mismatch_cnt == 0) begin
      $display("binary_greedy_pursuit_row test passed");
    end else begin
      $display("binary_greedy_pursuit_row test failed");
    end
    $finish;
  end

endmodule

// ----- binary_greedy_pursuit_row.f -----
+incdir+rtl
rtl/bgp_pkg.sv
rtl/bgp_atom_mem.sv
rtl/bgp_engine.sv
rtl/binary_greedy_pursuit_row.sv
rtl/bgp_checker.sv
tb/tb_binary_greedy_pursuit_row.sv
